/* src/slb_pkg.sv */
// Shared types, constants and helpers of the stroked line bounds block.
`default_nettype none

package slb_pkg;

  localparam int FracBitsDef = 16;

  typedef enum logic [1:0] {
    CAP_BUTT   = 2'd0,
    CAP_ROUND  = 2'd1,
    CAP_SQUARE = 2'd2
  } cap_e;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] stroke_width;
    logic [1:0]         cap_style;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] m31;
    logic signed [31:0] m32;
  } item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
  } box_t;

  // Clamps a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/slb_if.sv */
// Valid/ready channel interfaces for segment items and bounds results.
`default_nettype none

interface slb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] stroke_width;
  logic [1:0]         cap_style;
  logic signed [31:0] m11;
  logic signed [31:0] m12;
  logic signed [31:0] m21;
  logic signed [31:0] m22;
  logic signed [31:0] m31;
  logic signed [31:0] m32;

  modport source (output valid, start_x, start_y, end_x, end_y, stroke_width, cap_style,
                  m11, m12, m21, m22, m31, m32, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, stroke_width, cap_style,
                m11, m12, m21, m22, m31, m32, output ready);
endinterface

interface slb_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] min_x;
  logic signed [31:0] min_y;
  logic signed [31:0] max_x;
  logic signed [31:0] max_y;

  modport source (output valid, ok, min_x, min_y, max_x, max_y, input ready);
  modport sink (input valid, ok, min_x, min_y, max_x, max_y, output ready);
endinterface

`default_nettype wire

/* src/stroked_line_bounds_top.sv */
// Throughput: one segment per cycle unless the output buffer is full and not read;
// the square root and the two dividers each retire one bit per stage, which sets
// the depth of the pipeline.
// A two-entry output buffer keeps input transfers going while a result waits.
// Reset clears all valid bits and the buffer; data registers are not reset.
`default_nettype none

module stroked_line_bounds_top #(
  parameter int FRAC_BITS = slb_pkg::FracBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  slb_in_if.sink    in_i,
  slb_out_if.source out_o
);

  localparam logic [63:0] Half = 64'd1 << (FRAC_BITS - 1);

  function automatic logic signed [63:0] rnd_q(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    r   = (mag + Half) >> FRAC_BITS;
    return p[63] ? -$signed(r) : $signed(r);
  endfunction

  logic                en;
  slb_pkg::item_t      item;
  logic                dv;
  slb_pkg::item_t      ditem;
  logic signed [33:0]  xd;
  logic signed [33:0]  yd;

  always_comb begin
    item.start_x      = in_i.start_x;
    item.start_y      = in_i.start_y;
    item.end_x        = in_i.end_x;
    item.end_y        = in_i.end_y;
    item.stroke_width = in_i.stroke_width;
    item.cap_style    = in_i.cap_style;
    item.m11          = in_i.m11;
    item.m12          = in_i.m12;
    item.m21          = in_i.m21;
    item.m22          = in_i.m22;
    item.m31          = in_i.m31;
    item.m32          = in_i.m32;
  end

  assign in_i.ready = en;

  slb_delta u_delta (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .item_i   (item),
    .valid_o  (dv),
    .item_o   (ditem),
    .x_delta_o(xd),
    .y_delta_o(yd)
  );

  // Corner points before the transform.
  logic signed [31:0] pt_x_d [4];
  logic signed [31:0] pt_y_d [4];
  logic               ok_d;

  always_comb begin
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic signed [32:0] w1;
    logic signed [34:0] hw;
    logic signed [34:0] lx;
    logic signed [34:0] hx;
    logic signed [34:0] ly;
    logic signed [34:0] hy;
    logic signed [34:0] exd;
    logic signed [34:0] eyd;
    x1  = ditem.start_x;
    y1  = ditem.start_y;
    x2  = ditem.end_x;
    y2  = ditem.end_y;
    w1  = {ditem.stroke_width[31], ditem.stroke_width} + 33'sd1;
    hw  = {2'b00, w1} >>> 1;
    lx  = ((x1 < x2) ? 35'(x1) : 35'(x2)) - hw;
    hx  = ((x1 < x2) ? 35'(x2) : 35'(x1)) + hw;
    ly  = ((y1 < y2) ? 35'(y1) : 35'(y2)) - hw;
    hy  = ((y1 < y2) ? 35'(y2) : 35'(y1)) + hw;
    exd = 35'(xd);
    eyd = 35'(yd);
    ok_d = 1'b1;
    if (ditem.stroke_width <= 32'sd0) begin
      pt_x_d[0] = x1; pt_y_d[0] = y1;
      pt_x_d[1] = x1; pt_y_d[1] = y1;
      pt_x_d[2] = x2; pt_y_d[2] = y2;
      pt_x_d[3] = x2; pt_y_d[3] = y2;
    end else if (ditem.cap_style == slb_pkg::CAP_ROUND) begin
      ok_d = ((ditem.m12 == 32'sd0) && (ditem.m21 == 32'sd0)) ||
             ((ditem.m11 == 32'sd0) && (ditem.m22 == 32'sd0));
      pt_x_d[0] = slb_pkg::sat32(66'(lx)); pt_y_d[0] = slb_pkg::sat32(66'(ly));
      pt_x_d[1] = slb_pkg::sat32(66'(hx)); pt_y_d[1] = slb_pkg::sat32(66'(ly));
      pt_x_d[2] = slb_pkg::sat32(66'(lx)); pt_y_d[2] = slb_pkg::sat32(66'(hy));
      pt_x_d[3] = slb_pkg::sat32(66'(hx)); pt_y_d[3] = slb_pkg::sat32(66'(hy));
    end else begin
      pt_x_d[0] = slb_pkg::sat32(66'(35'(x1) - exd));
      pt_y_d[0] = slb_pkg::sat32(66'(35'(y1) - eyd));
      pt_x_d[1] = slb_pkg::sat32(66'(35'(x1) + exd));
      pt_y_d[1] = slb_pkg::sat32(66'(35'(y1) + eyd));
      pt_x_d[2] = slb_pkg::sat32(66'(35'(x2) + exd));
      pt_y_d[2] = slb_pkg::sat32(66'(35'(y2) + eyd));
      pt_x_d[3] = slb_pkg::sat32(66'(35'(x2) - exd));
      pt_y_d[3] = slb_pkg::sat32(66'(35'(y2) - eyd));
    end
  end

  logic               pv_q, m1v_q, m2v_q, sv_q;
  logic               pok_q, m1ok_q, m2ok_q, sok_q;
  logic signed [31:0] pt_x_q [4];
  logic signed [31:0] pt_y_q [4];
  logic signed [31:0] m11_q, m12_q, m21_q, m22_q;
  logic signed [31:0] pm31_q, pm32_q, m1m31_q, m1m32_q, m2m31_q, m2m32_q;
  logic signed [63:0] pxa_q [4];
  logic signed [63:0] pxb_q [4];
  logic signed [63:0] pya_q [4];
  logic signed [63:0] pyb_q [4];
  logic signed [63:0] rxa_q [4];
  logic signed [63:0] rxb_q [4];
  logic signed [63:0] rya_q [4];
  logic signed [63:0] ryb_q [4];
  logic signed [31:0] tx_q [4];
  logic signed [31:0] ty_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      m1v_q <= 1'b0;
      m2v_q <= 1'b0;
      sv_q  <= 1'b0;
    end else if (en) begin
      pv_q  <= dv;
      m1v_q <= pv_q;
      m2v_q <= m1v_q;
      sv_q  <= m2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pok_q   <= ok_d;
      pt_x_q  <= pt_x_d;
      pt_y_q  <= pt_y_d;
      m11_q   <= ditem.m11;
      m12_q   <= ditem.m12;
      m21_q   <= ditem.m21;
      m22_q   <= ditem.m22;
      pm31_q  <= ditem.m31;
      pm32_q  <= ditem.m32;
      m1ok_q  <= pok_q;
      m1m31_q <= pm31_q;
      m1m32_q <= pm32_q;
      m2ok_q  <= m1ok_q;
      m2m31_q <= m1m31_q;
      m2m32_q <= m1m32_q;
      sok_q   <= m2ok_q;
      for (int k = 0; k < 4; k++) begin
        pxa_q[k] <= pt_x_q[k] * m11_q;
        pxb_q[k] <= pt_y_q[k] * m21_q;
        pya_q[k] <= pt_x_q[k] * m12_q;
        pyb_q[k] <= pt_y_q[k] * m22_q;
        rxa_q[k] <= rnd_q(pxa_q[k]);
        rxb_q[k] <= rnd_q(pxb_q[k]);
        rya_q[k] <= rnd_q(pya_q[k]);
        ryb_q[k] <= rnd_q(pyb_q[k]);
        tx_q[k]  <= slb_pkg::sat32(66'(rxa_q[k]) + 66'(rxb_q[k]) + 66'(m2m31_q));
        ty_q[k]  <= slb_pkg::sat32(66'(rya_q[k]) + 66'(ryb_q[k]) + 66'(m2m32_q));
      end
    end
  end

  // Bounds over the four transformed points.
  slb_pkg::box_t box_d;
  always_comb begin
    logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
    lo_x = tx_q[0]; hi_x = tx_q[0];
    lo_y = ty_q[0]; hi_y = ty_q[0];
    for (int k = 1; k < 4; k++) begin
      if (tx_q[k] < lo_x) lo_x = tx_q[k];
      if (tx_q[k] > hi_x) hi_x = tx_q[k];
      if (ty_q[k] < lo_y) lo_y = ty_q[k];
      if (ty_q[k] > hi_y) hi_y = ty_q[k];
    end
    box_d.ok    = sok_q;
    box_d.min_x = sok_q ? lo_x : '0;
    box_d.min_y = sok_q ? lo_y : '0;
    box_d.max_x = sok_q ? hi_x : '0;
    box_d.max_y = sok_q ? hi_y : '0;
  end

  // Two-entry output buffer.
  slb_pkg::box_t buf_q [2];
  logic          rd_q, wr_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign pop  = out_o.valid && out_o.ready;
  assign en   = (cnt_q != 2'd2) || pop;
  assign push = sv_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= box_d;
    end
  end

  always_comb begin
    slb_pkg::box_t head;
    head        = buf_q[rd_q];
    out_o.valid = cnt_q != 2'd0;
    out_o.ok    = head.ok;
    out_o.min_x = head.min_x;
    out_o.min_y = head.min_y;
    out_o.max_x = head.max_x;
    out_o.max_y = head.max_y;
  end

endmodule

`default_nettype wire

/* src/slb_delta.sv */
// Cap offset pipeline: direction, normalization, square root and two dividers.
`default_nettype none

module slb_delta (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire slb_pkg::item_t      item_i,
  output logic                     valid_o,
  output slb_pkg::item_t           item_o,
  output logic signed [33:0]       x_delta_o,
  output logic signed [33:0]       y_delta_o
);

  localparam int SqSteps   = 32;
  localparam int DivSteps  = 32;
  localparam int SqBase    = 3;
  localparam int MulIdx    = SqBase + SqSteps;
  localparam int DivBase   = MulIdx + 1;
  localparam int NumStages = DivBase + DivSteps;

  typedef struct packed {
    slb_pkg::item_t item;
    logic           dxn;
    logic           dyn;
    logic           zero;
    logic [31:0]    ax;
    logic [31:0]    ay;
    logic [63:0]    rad;
    logic [63:0]    root;
    logic [63:0]    num_a;
    logic [63:0]    num_b;
    logic [32:0]    den;
    logic [33:0]    rem_a;
    logic [33:0]    rem_b;
    logic [31:0]    q_a;
    logic [31:0]    q_b;
  } dst_t;

  dst_t                 st_q [NumStages];
  dst_t                 st_d [NumStages];
  logic [NumStages-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NumStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  // Differences, their signs and magnitudes.
  dst_t s0_nx;
  always_comb begin
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] adx;
    logic signed [32:0] ady;
    s0_nx      = '0;
    s0_nx.item = item_i;
    dx = {item_i.end_x[31], item_i.end_x} - {item_i.start_x[31], item_i.start_x};
    dy = {item_i.end_y[31], item_i.end_y} - {item_i.start_y[31], item_i.start_y};
    adx = dx[32] ? -dx : dx;
    ady = dy[32] ? -dy : dy;
    s0_nx.dxn  = dx[32];
    s0_nx.dyn  = dy[32];
    s0_nx.ax   = adx[31:0];
    s0_nx.ay   = ady[31:0];
    s0_nx.zero = (dx == 33'sd0) && (dy == 33'sd0);
  end
  assign st_d[0] = s0_nx;

  // Scale both magnitudes so the larger lies in [2^30, 2^31).
  dst_t s1_nx;
  always_comb begin
    logic [31:0] mx;
    logic [4:0]  lz;
    s1_nx = st_q[0];
    mx = (st_q[0].ax > st_q[0].ay) ? st_q[0].ax : st_q[0].ay;
    lz = 5'd31;
    for (int i = 0; i < 31; i++) begin
      if (mx[i]) begin
        lz = 5'(30 - i);
      end
    end
    if (mx[31]) begin
      s1_nx.ax = st_q[0].ax >> 1;
      s1_nx.ay = st_q[0].ay >> 1;
    end else begin
      s1_nx.ax = st_q[0].ax << lz;
      s1_nx.ay = st_q[0].ay << lz;
    end
  end
  assign st_d[1] = s1_nx;

  // Sum of squares.
  dst_t s2_nx;
  always_comb begin
    logic [61:0] sqx;
    logic [61:0] sqy;
    s2_nx = st_q[1];
    sqx = st_q[1].ax[30:0] * st_q[1].ax[30:0];
    sqy = st_q[1].ay[30:0] * st_q[1].ay[30:0];
    s2_nx.rad  = 64'(sqx) + 64'(sqy);
    s2_nx.root = '0;
  end
  assign st_d[2] = s2_nx;

  // Floor square root, one result bit per stage.
  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    dst_t nx;
    always_comb begin
      logic [63:0] bitv;
      logic [63:0] t;
      nx   = st_q[SqBase + k - 1];
      bitv = 64'd1 << (62 - 2 * k);
      t    = nx.root + bitv;
      if (nx.rad >= t) begin
        nx.rad  = nx.rad - t;
        nx.root = (nx.root >> 1) + bitv;
      end else begin
        nx.root = nx.root >> 1;
      end
    end
    assign st_d[SqBase + k] = nx;
  end

  // Dividends with the rounding term, and the divisor of twice the length.
  dst_t sm_nx;
  always_comb begin
    logic [31:0] len;
    logic [30:0] w;
    logic [31:0] sel;
    logic [62:0] pa;
    logic [62:0] pb;
    sm_nx = st_q[MulIdx - 1];
    len   = sm_nx.root[31:0];
    w     = sm_nx.item.stroke_width[30:0];
    sel   = (sm_nx.item.cap_style == slb_pkg::CAP_BUTT) ? sm_nx.ay : sm_nx.ax + sm_nx.ay;
    pa    = w * sel;
    pb    = w * sm_nx.ax;
    sm_nx.num_a = 64'(pa) + 64'(len);
    sm_nx.num_b = 64'(pb) + 64'(len);
    sm_nx.den   = {len, 1'b0};
    sm_nx.rem_a = {2'b00, sm_nx.num_a[63:32]};
    sm_nx.rem_b = {2'b00, sm_nx.num_b[63:32]};
    sm_nx.q_a   = '0;
    sm_nx.q_b   = '0;
  end
  assign st_d[MulIdx] = sm_nx;

  // Restoring division, one quotient bit per stage for both dividers.
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    dst_t nx;
    always_comb begin
      logic [33:0] ta;
      logic [33:0] tb;
      nx = st_q[DivBase + i - 1];
      ta = {nx.rem_a[32:0], nx.num_a[DivSteps - 1 - i]};
      tb = {nx.rem_b[32:0], nx.num_b[DivSteps - 1 - i]};
      if (ta >= {1'b0, nx.den}) begin
        nx.rem_a = ta - {1'b0, nx.den};
        nx.q_a[DivSteps - 1 - i] = 1'b1;
      end else begin
        nx.rem_a = ta;
      end
      if (tb >= {1'b0, nx.den}) begin
        nx.rem_b = tb - {1'b0, nx.den};
        nx.q_b[DivSteps - 1 - i] = 1'b1;
      end else begin
        nx.rem_b = tb;
      end
    end
    assign st_d[DivBase + i] = nx;
  end

  // Signed offsets for the cap style.
  always_comb begin
    dst_t               p;
    logic signed [32:0] w1;
    logic signed [33:0] hw;
    logic signed [33:0] qa;
    logic signed [33:0] qb;
    p  = st_q[NumStages - 1];
    w1 = {p.item.stroke_width[31], p.item.stroke_width} + 33'sd1;
    hw = {1'b0, w1} >>> 1;
    qa = $signed({2'b00, p.q_a});
    qb = $signed({2'b00, p.q_b});
    if (p.zero) begin
      if (p.item.cap_style == slb_pkg::CAP_BUTT) begin
        x_delta_o = '0;
        y_delta_o = '0;
      end else begin
        x_delta_o = hw;
        y_delta_o = hw;
      end
    end else if (p.item.cap_style == slb_pkg::CAP_BUTT) begin
      x_delta_o = p.dyn ? -qa : qa;
      y_delta_o = p.dxn ? qb : -qb;
    end else begin
      x_delta_o = qa;
      y_delta_o = qa;
    end
    item_o  = p.item;
    valid_o = v_q[NumStages - 1];
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the stroked line bounds block with a fixed-point predictor.
`default_nettype none

module testbench;

  localparam int FB = slb_pkg::FracBitsDef;
  localparam int DrainCycles = 200;
  localparam longint CycleLimit = 2000000;
  localparam int LongHold = 300;
  localparam int One = 32'h00010000;
  localparam int MaxI = 32'h7fffffff;
  localparam int MinI = 32'h80000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  slb_in_if in_ch ();
  slb_out_if out_ch ();

  stroked_line_bounds_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  typedef struct {
    slb_pkg::item_t seg;
    logic           has_exp;
    slb_pkg::box_t  exp;
  } row_t;

  slb_pkg::box_t pending_boxes[$];
  row_t          directed_rows[$];
  int            fail_count = 0;
  bit            table_ok = 1'b1;
  longint        cycle_count = 0;
  int            src_idle_pct = 0;
  int            snk_idle_pct = 0;
  int            snk_hold = 0;
  int            hold_req = 0;
  int            hold_ack = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    longint unsigned m;
    p = a * b;
    m = (p < 0) ? longint'(-p) : longint'(p);
    m = (m + (64'd1 << (FB - 1))) >> FB;
    return (p < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void grow_box(input slb_pkg::item_t s, input longint x, input longint y,
                                   inout logic used, inout longint bx[4]);
    longint px, py;
    x = clamp32(x);
    y = clamp32(y);
    px = clamp32(fx_mul(x, s.m11) + fx_mul(y, s.m21) + longint'(s.m31));
    py = clamp32(fx_mul(x, s.m12) + fx_mul(y, s.m22) + longint'(s.m32));
    if (!used) begin
      bx[0] = px; bx[2] = px; bx[1] = py; bx[3] = py;
      used = 1'b1;
    end else begin
      if (px < bx[0]) bx[0] = px;
      if (px > bx[2]) bx[2] = px;
      if (py < bx[1]) bx[1] = py;
      if (py > bx[3]) bx[3] = py;
    end
  endfunction

  function automatic slb_pkg::box_t predict_bounds(slb_pkg::item_t s);
    longint x1, y1, x2, y2, w, xd, yd, hw, dx, dy, q;
    longint unsigned ax, ay, mx, len, twol;
    longint bx[4];
    logic   used, rect;
    slb_pkg::box_t r;
    x1 = s.start_x; y1 = s.start_y; x2 = s.end_x; y2 = s.end_y;
    w = s.stroke_width;
    xd = 0; yd = 0; used = 1'b0;
    bx = '{0, 0, 0, 0};
    r.ok = 1'b1;
    if (w <= 0) begin
      grow_box(s, x1, y1, used, bx);
      grow_box(s, x2, y2, used, bx);
    end else if (s.cap_style == slb_pkg::CAP_ROUND) begin
      rect = (s.m12 == 0 && s.m21 == 0) || (s.m11 == 0 && s.m22 == 0);
      if (!rect) begin
        r.ok = 1'b0;
      end else begin
        hw = (w + 1) >>> 1;
        grow_box(s, ((x1 < x2) ? x1 : x2) - hw, ((y1 < y2) ? y1 : y2) - hw, used, bx);
        grow_box(s, ((x1 < x2) ? x2 : x1) + hw, ((y1 < y2) ? y1 : y2) - hw, used, bx);
        grow_box(s, ((x1 < x2) ? x1 : x2) - hw, ((y1 < y2) ? y2 : y1) + hw, used, bx);
        grow_box(s, ((x1 < x2) ? x2 : x1) + hw, ((y1 < y2) ? y2 : y1) + hw, used, bx);
      end
    end else begin
      dx = x2 - x1;
      dy = y2 - y1;
      if (dx == 0 && dy == 0) begin
        if (s.cap_style != slb_pkg::CAP_BUTT) begin
          xd = (w + 1) >>> 1;
          yd = xd;
        end
      end else begin
        ax = (dx < 0) ? longint'(-dx) : longint'(dx);
        ay = (dy < 0) ? longint'(-dy) : longint'(dy);
        mx = (ax > ay) ? ax : ay;
        while (mx >= (64'd1 << 31)) begin
          ax = ax >> 1; ay = ay >> 1; mx = mx >> 1;
        end
        while (mx < (64'd1 << 30)) begin
          ax = ax << 1; ay = ay << 1; mx = mx << 1;
        end
        len = floor_sqrt(ax * ax + ay * ay);
        twol = 2 * len;
        if (s.cap_style == slb_pkg::CAP_BUTT) begin
          q = longint'((longint'(w) * ay + len) / twol);
          xd = (dy < 0) ? -q : q;
          q = longint'((longint'(w) * ax + len) / twol);
          yd = (dx < 0) ? q : -q;
        end else begin
          xd = longint'((longint'(w) * (ax + ay) + len) / twol);
          yd = xd;
        end
      end
      grow_box(s, x1 - xd, y1 - yd, used, bx);
      grow_box(s, x1 + xd, y1 + yd, used, bx);
      grow_box(s, x2 + xd, y2 + yd, used, bx);
      grow_box(s, x2 - xd, y2 - yd, used, bx);
    end
    r.min_x = r.ok ? bx[0][31:0] : '0;
    r.min_y = r.ok ? bx[1][31:0] : '0;
    r.max_x = r.ok ? bx[2][31:0] : '0;
    r.max_y = r.ok ? bx[3][31:0] : '0;
    return r;
  endfunction

  function automatic slb_pkg::item_t make_seg(int sx, int sy, int ex, int ey, int w,
                                              logic [1:0] cap, int a, int b, int c, int d,
                                              int tx, int ty);
    slb_pkg::item_t s;
    s.start_x = sx; s.start_y = sy; s.end_x = ex; s.end_y = ey;
    s.stroke_width = w; s.cap_style = cap;
    s.m11 = a; s.m12 = b; s.m21 = c; s.m22 = d; s.m31 = tx; s.m32 = ty;
    return s;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fffffff - $urandom_range(0, 3);
      2: return 32'h80000000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
    endcase
  endfunction

  function automatic logic [31:0] rand_term();
    case ($urandom_range(0, 6))
      0: return 32'h0;
      1: return $urandom();
      2: return 32'h00010000;
      3: return 32'hffff0000;
      default: return $signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000;
    endcase
  endfunction

  function automatic slb_pkg::item_t rand_seg();
    slb_pkg::item_t s;
    s.start_x = rand_coord(); s.start_y = rand_coord();
    if ($urandom_range(0, 9) == 0) begin
      s.end_x = s.start_x; s.end_y = s.start_y;
    end else if ($urandom_range(0, 4) == 0) begin
      s.end_x = s.start_x; s.end_y = rand_coord();
    end else begin
      s.end_x = rand_coord(); s.end_y = rand_coord();
    end
    case ($urandom_range(0, 5))
      0: s.stroke_width = -$signed($urandom_range(0, 32'h00100000));
      1: s.stroke_width = $urandom();
      default: s.stroke_width = $urandom_range(1, 32'h00400000);
    endcase
    s.cap_style = 2'($urandom_range(0, 3));
    s.m11 = rand_term(); s.m12 = rand_term(); s.m21 = rand_term(); s.m22 = rand_term();
    if (s.cap_style == slb_pkg::CAP_ROUND && $urandom_range(0, 1)) begin
      if ($urandom_range(0, 1)) begin
        s.m12 = 0; s.m21 = 0;
      end else begin
        s.m11 = 0; s.m22 = 0;
      end
    end
    s.m31 = rand_coord(); s.m32 = rand_coord();
    return s;
  endfunction

  // Valid stays high after a transfer so that the next call can follow without a gap.
  task automatic send_segment(slb_pkg::item_t s);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.start_x <= s.start_x; in_ch.start_y <= s.start_y;
    in_ch.end_x <= s.end_x; in_ch.end_y <= s.end_y;
    in_ch.stroke_width <= s.stroke_width; in_ch.cap_style <= s.cap_style;
    in_ch.m11 <= s.m11; in_ch.m12 <= s.m12; in_ch.m21 <= s.m21; in_ch.m22 <= s.m22;
    in_ch.m31 <= s.m31; in_ch.m32 <= s.m32;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    slb_pkg::box_t got, want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.ok, out_ch.min_x, out_ch.min_y, out_ch.max_x, out_ch.max_y};
      if (pending_boxes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_count++;
      end else begin
        want = pending_boxes.pop_front();
        if (got.ok !== want.ok) begin
          $display("%0t: ok expected %b actual %b", $time, want.ok, got.ok);
          fail_count++;
        end
        if (got.min_x !== want.min_x) begin
          $display("%0t: min_x expected %h actual %h", $time, want.min_x, got.min_x);
          fail_count++;
        end
        if (got.min_y !== want.min_y) begin
          $display("%0t: min_y expected %h actual %h", $time, want.min_y, got.min_y);
          fail_count++;
        end
        if (got.max_x !== want.max_x) begin
          $display("%0t: max_x expected %h actual %h", $time, want.max_x, got.max_x);
          fail_count++;
        end
        if (got.max_y !== want.max_y) begin
          $display("%0t: max_y expected %h actual %h", $time, want.max_y, got.max_y);
          fail_count++;
        end
      end
    end
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      pending_boxes.push_back(predict_bounds('{in_ch.start_x, in_ch.start_y, in_ch.end_x,
          in_ch.end_y, in_ch.stroke_width, in_ch.cap_style, in_ch.m11, in_ch.m12,
          in_ch.m21, in_ch.m22, in_ch.m31, in_ch.m32}));
    end
  end

  // The receiver stalls at random, or for a long stretch while snk_hold counts down.
  always @(negedge clk_i) begin
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      snk_hold <= LongHold - 1;
      out_ch.ready <= 1'b0;
    end else if (snk_hold > 0) begin
      snk_hold <= snk_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct);
    end
  end

  initial begin
    row_t          r;
    slb_pkg::box_t want;
    int            drain;
    in_ch.valid = 1'b0;
    in_ch.start_x = 0; in_ch.start_y = 0; in_ch.end_x = 0; in_ch.end_y = 0;
    in_ch.stroke_width = 0; in_ch.cap_style = slb_pkg::CAP_BUTT;
    in_ch.m11 = 0; in_ch.m12 = 0; in_ch.m21 = 0; in_ch.m22 = 0; in_ch.m31 = 0; in_ch.m32 = 0;

    // Rows with a typed-in result are the ones that can be read off directly.
    r.has_exp = 1'b0;
    r.seg = make_seg(0, 0, 3 * One, 4 * One, 0, slb_pkg::CAP_BUTT, One, 0, 0, One, 0, 0);
    r.has_exp = 1'b1; r.exp = '{1'b1, 0, 0, 3 * One, 4 * One};
    directed_rows.push_back(r);
    r.seg = make_seg(0, 0, One, One, One, slb_pkg::CAP_ROUND, One, One, 0, One, 0, 0);
    r.exp = '{1'b0, 0, 0, 0, 0};
    directed_rows.push_back(r);
    r.seg = make_seg(MaxI, MaxI, MinI, MinI, -One, slb_pkg::CAP_SQUARE, One, 0, 0, One, 0, 0);
    r.exp = '{1'b1, MinI, MinI, MaxI, MaxI};
    directed_rows.push_back(r);
    r.seg = make_seg(One, One, One, One, 2 * One, slb_pkg::CAP_BUTT, One, 0, 0, One, 0, 0);
    r.exp = '{1'b1, One, One, One, One};
    directed_rows.push_back(r);
    r.seg = make_seg(One, One, One, One, 2 * One, slb_pkg::CAP_SQUARE, One, 0, 0, One, 0, 0);
    r.exp = '{1'b1, 0, 0, 2 * One, 2 * One};
    directed_rows.push_back(r);
    r.seg = make_seg(0, 0, 0, 0, 2 * One, slb_pkg::CAP_ROUND, 0, One, One, 0, 0, 0);
    r.exp = '{1'b1, -One, -One, One, One};
    directed_rows.push_back(r);
    r.seg = make_seg(0, 0, 0, 0, MinI, slb_pkg::CAP_ROUND, MaxI, MaxI, MaxI, MaxI, MaxI, MaxI);
    r.exp = '{1'b1, MaxI, MaxI, MaxI, MaxI};
    directed_rows.push_back(r);
    r.has_exp = 1'b0;
    r.seg = make_seg(0, 0, 4 * One, 0, 2 * One, slb_pkg::CAP_BUTT, One, 0, 0, One, One, One);
    directed_rows.push_back(r);
    r.seg = make_seg(0, 0, 0, -4 * One, 2 * One, slb_pkg::CAP_BUTT, One, 0, 0, One, 0, 0);
    directed_rows.push_back(r);
    r.seg = make_seg(0, 0, -3 * One, 4 * One, 2 * One, slb_pkg::CAP_SQUARE,
                     One, 0, 0, One, 0, 0);
    directed_rows.push_back(r);
    r.seg = make_seg(MinI, MinI, MaxI, MaxI, MaxI, slb_pkg::CAP_BUTT,
                     MinI, MaxI, MinI, MaxI, MinI, MaxI);
    directed_rows.push_back(r);
    r.seg = make_seg(MaxI, MinI, MinI, MaxI, MaxI, 2'd3, -One, 0, 0, MinI, MaxI, MinI);
    directed_rows.push_back(r);
    r.seg = make_seg(MaxI, MaxI, MinI, MinI, MaxI, slb_pkg::CAP_ROUND, MaxI, 0, 0, MinI, 0, 0);
    directed_rows.push_back(r);
    r.seg = make_seg(1, 0, 0, 1, 1, slb_pkg::CAP_BUTT, -1, -1, -1, -1, -1, -1);
    directed_rows.push_back(r);
    r.seg = make_seg(5, 7, 5, 8, 3, slb_pkg::CAP_SQUARE, One / 2, One / 3, -One, 7, 9, -9);
    directed_rows.push_back(r);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].has_exp) begin
        want = predict_bounds(directed_rows[i].seg);
        if (want !== directed_rows[i].exp) begin
          $display("%0t: row %0d expected %h actual %h", $time, i, directed_rows[i].exp, want);
          table_ok = 1'b0;
        end
      end
      send_segment(directed_rows[i].seg);
    end

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 60 : 0;
      snk_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 38 : 0;
      for (int n = 0; n < 400; n++) begin
        if (n == 100) hold_req = hold_req + 1;
        if (n == 250) begin
          in_ch.valid <= 1'b0;
          while (pending_boxes.size() != 0) @(negedge clk_i);
        end
        send_segment(rand_seg());
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk_i);
    drain = 0;
    while (drain < DrainCycles) begin
      @(negedge clk_i);
      drain++;
    end
    if (fail_count == 0 && table_ok && pending_boxes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
src/slb_pkg.sv
src/slb_if.sv
src/slb_delta.sv
src/stroked_line_bounds_top.sv
tb/testbench.sv
